// ----- src/timer_epoch_extender_unit_assert.svh -----
// Assertion macros for the timer epoch extender RTL.
// Needs aclk and aresetn in the scope of the module that uses them.
`ifndef TIMER_EPOCH_EXTENDER_UNIT_ASSERT_SVH
`define TIMER_EPOCH_EXTENDER_UNIT_ASSERT_SVH

// same-cycle implication
`define TEE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TEE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/tee_pkg.sv -----
// Types and constants for the timer epoch extender.
// No dependencies.
package tee_pkg;

    localparam int FINE_W   = 10;
    localparam int STORE_W  = 9;
    localparam int PER_W    = 24;
    localparam int SYM_W    = 32;
    localparam int STATUS_W = 2;

    localparam logic [PER_W-1:0]   WRAP_PERIOD = 24'hFF_FFFF;
    localparam logic [PER_W-1:0]   HALF_WHOLE  = 24'h7F_FFFF;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_ARG   = 2'd1,
        ST_BAD_STATE = 2'd2,
        ST_TIME_ERR  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_READY = 3'b010,
        MODE_FAULT = 3'b100
    } mode_t;

    typedef struct packed {
        logic               op;
        logic [FINE_W-1:0]  timer_fine;
        logic [PER_W-1:0]   timer_periods;
        logic [SYM_W-1:0]   start_symbols;
    } item_t;

    typedef struct packed {
        status_t             status;
        logic [SYM_W-1:0]    symbol_total;
        logic [STORE_W-1:0]  fine_out;
    } result_t;

endpackage

// ----- src/tee_core.sv -----
// Epoch state and combinational step/start evaluation.
// Depends on tee_pkg and timer_epoch_extender_unit_assert.svh.
`include "timer_epoch_extender_unit_assert.svh"

module tee_core import tee_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    fire,
    input  item_t   item,
    output result_t result
);

    mode_t              mode_reg, mode_next;
    logic [PER_W-1:0]   last_per_reg, last_per_next;
    logic [STORE_W-1:0] last_fine_reg, last_fine_next;
    logic [SYM_W-1:0]   count_reg, count_next;

    logic               stamp_ok;
    logic               borrow;
    logic [PER_W-1:0]   diff;
    logic [PER_W-1:0]   whole;
    logic [STORE_W-1:0] frac;
    logic               gap_bad;
    logic [STORE_W-1:0] new_fine;

    assign new_fine = item.timer_fine[STORE_W-1:0];
    assign stamp_ok = !item.timer_fine[FINE_W-1] && (item.timer_periods != WRAP_PERIOD);
    assign diff     = (item.timer_periods >= last_per_reg) ?
                      item.timer_periods - last_per_reg :
                      item.timer_periods + WRAP_PERIOD - last_per_reg;
    assign borrow   = new_fine < last_fine_reg;
    assign whole    = borrow ? diff - 24'd1 : diff;
    assign frac     = new_fine - last_fine_reg;
    assign gap_bad  = (whole > HALF_WHOLE) || ((whole == HALF_WHOLE) && frac[STORE_W-1]);

    always_comb begin
        mode_next      = mode_reg;
        last_per_next  = last_per_reg;
        last_fine_next = last_fine_reg;
        count_next     = count_reg;
        result         = '{status: ST_OK, symbol_total: '0, fine_out: '0};
        if (item.op == OP_START) begin
            if (!stamp_ok) begin
                result.status = ST_BAD_ARG;
            end else begin
                last_per_next  = item.timer_periods;
                last_fine_next = new_fine;
                count_next     = item.start_symbols;
                mode_next      = MODE_READY;
            end
        end else if (mode_reg == MODE_FAULT) begin
            result.status = ST_TIME_ERR;
        end else if (!stamp_ok) begin
            result.status = ST_BAD_ARG;
        end else if (mode_reg != MODE_READY) begin
            result.status = ST_BAD_STATE;
        end else if ((borrow && diff == '0) || gap_bad) begin
            result.status = ST_TIME_ERR;
            mode_next     = MODE_FAULT;
        end else begin
            count_next          = count_reg + {{(SYM_W-PER_W){1'b0}}, diff};
            last_per_next       = item.timer_periods;
            last_fine_next      = new_fine;
            result.symbol_total = count_next;
            result.fine_out     = new_fine;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_IDLE;
            last_per_reg  <= '0;
            last_fine_reg <= '0;
            count_reg     <= '0;
        end else if (fire) begin
            mode_reg      <= mode_next;
            last_per_reg  <= last_per_next;
            last_fine_reg <= last_fine_next;
            count_reg     <= count_next;
        end
    end

    `TEE_ASSERT_NEXT(a_fault_sticks, mode_reg == MODE_FAULT && !(fire && item.op == OP_START), mode_reg == MODE_FAULT, "fault cleared without start")
    `TEE_ASSERT_NEXT(a_no_return_idle, mode_reg != MODE_IDLE, mode_reg != MODE_IDLE, "mode fell back to idle")
    `TEE_ASSERT_NEXT(a_err_keeps_count, fire && result.status != ST_OK, $stable(count_reg) && $stable(last_per_reg), "error changed stored epoch")
    `TEE_ASSERT_NEXT(a_step_count, fire && item.op == OP_STEP && result.status == ST_OK, count_reg == $past(result.symbol_total), "step total not stored")
    `TEE_ASSERT_NOW(a_err_zero, result.status != ST_OK, result.symbol_total == '0 && result.fine_out == '0, "error result not zeroed")

endmodule

// ----- src/timer_epoch_extender_unit.sv -----
// Top level of the timer epoch extender: input beat register, core, result register.
// Depends on tee_pkg and tee_core.
//
// Usage:
//   Slave channel s_*: one beat per stamp. s_tuser[0] is op (0 start, 1 step).
//   A start beat seeds the stored stamp and running count; a step beat extends
//   the count by the period gap to the new stamp and returns the new total.
//   Master channel m_*: exactly one result beat for every accepted input beat,
//   in order. m_tuser carries the status; totals are zero on any error.
// Path: an accepted beat lands in the input register and its result in the
//   result register; the step math sits between them.
// Throughput: one beat per cycle, sustained while m_tready stays high, set by
//   the single compare/add path between the two registers.
// Stall: when m_tready is low the result register holds, the input register
//   holds behind it and s_tready drops once both are full; nothing is lost.
// Reset: aresetn low (synchronous) empties both registers and returns the
//   epoch to idle; steps with a valid stamp answer invalid state until a valid start arrives.

module timer_epoch_extender_unit import tee_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // timer_fine[9:0], timer_periods[33:10], start_symbols[65:34]
    input  logic [0:0]  s_tuser,   // op[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // symbol_total[31:0], fine_out[40:32]
    output logic [1:0]  m_tuser    // status[1:0]
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t core_res;
    logic    out_free;
    logic    fire;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg <= '{op:            s_tuser[0],
                             timer_fine:    s_tdata[9:0],
                             timer_periods: s_tdata[33:10],
                             start_symbols: s_tdata[65:34]};
        end
        if (fire) begin
            out_res_reg <= core_res;
        end
    end

    tee_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_item_reg),
        .result  (core_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_res_reg.fine_out, out_res_reg.symbol_total};
    assign m_tuser  = out_res_reg.status;

endmodule
